// ----- rtl/bptc_pkg.sv -----
package bptc_pkg;

  // Field widths of the transfers and the calibration words.
  localparam int unsigned RawW   = 24;
  localparam int unsigned CoeffW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PressW = 32;
  localparam int unsigned TempW  = 16;

  // Register stages from input acceptance to the output register.
  localparam int unsigned NumStages = 8;

  // Calibration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPressSens   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPressOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSensTemp    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOffsetTemp  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRefTemp     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTempSlope   = 3'd5;

  // Temperature of the first-order result at zero difference, in 0.01 C.
  localparam logic signed [18:0] TempBase = 19'sd2000;
  // Offset that moves -15.00 C to zero for the extra cold term.
  localparam logic signed [18:0] ColdShift = 19'sd3500;
  localparam logic signed [17:0] ColdLimit = -18'sd3500;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [PressW-1:0] pressure_centi_mbar;
    logic signed [TempW-1:0]  temperature_centi_deg;
  } out_t;

  typedef struct packed {
    logic [CoeffW-1:0] pressure_sensitivity_coeff;
    logic [CoeffW-1:0] pressure_offset_coeff;
    logic [CoeffW-1:0] sensitivity_temp_coeff;
    logic [CoeffW-1:0] offset_temp_coeff;
    logic [CoeffW-1:0] reference_temperature_coeff;
    logic [CoeffW-1:0] temperature_slope_coeff;
  } coeff_t;

  // First-order terms and the squares needed for the low-temperature fix.
  typedef struct packed {
    logic [RawW-1:0]     d1;
    logic signed [34:0]  off;
    logic signed [33:0]  sens;
    logic signed [17:0]  t;
    logic [16:0]         t2;
    logic [34:0]         tt;
    logic [33:0]         u;
  } front_t;

  // Corrected offset and sensitivity, and the finished temperature.
  typedef struct packed {
    logic [RawW-1:0]          d1;
    logic signed [39:0]       off;
    logic signed [37:0]       sens;
    logic signed [TempW-1:0]  temp;
  } corr_t;

endpackage

// ----- rtl/bptc_front.sv -----
// Stages 1 to 3: temperature difference, its products with the calibration
// words, and the squares used by the second-order correction.
module bptc_front (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  bptc_pkg::in_t       in_data_i,
  input  bptc_pkg::coeff_t    coeff_i,
  output bptc_pkg::front_t    front_o
);

  // Stage 1.
  logic [bptc_pkg::RawW-1:0] d1_s1_q;
  logic signed [24:0]        dt_s1_q, dt_s1_d;

  // Stage 2.
  logic [bptc_pkg::RawW-1:0] d1_s2_q;
  logic signed [40:0]        poff_q, poff_d;
  logic signed [40:0]        psens_q, psens_d;
  logic signed [40:0]        pt_q, pt_d;
  logic signed [49:0]        dd_full;
  logic [47:0]               dd_q;

  // Stage 3.
  logic signed [17:0]        t_w;
  logic signed [18:0]        tp_w;
  logic signed [35:0]        tt_full;
  logic signed [37:0]        u_full;
  bptc_pkg::front_t          front_q, front_d;

  assign dt_s1_d = $signed({1'b0, in_data_i.raw_temperature})
                 - $signed({1'b0, coeff_i.reference_temperature_coeff, 8'h00});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_s1_q <= in_data_i.raw_pressure;
      dt_s1_q <= dt_s1_d;
    end
  end

  assign poff_d  = $signed({1'b0, coeff_i.offset_temp_coeff}) * dt_s1_q;
  assign psens_d = $signed({1'b0, coeff_i.sensitivity_temp_coeff}) * dt_s1_q;
  assign pt_d    = $signed({1'b0, coeff_i.temperature_slope_coeff}) * dt_s1_q;
  assign dd_full = dt_s1_q * dt_s1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      d1_s2_q <= d1_s1_q;
      poff_q  <= poff_d;
      psens_q <= psens_d;
      pt_q    <= pt_d;
      dd_q    <= dd_full[47:0];
    end
  end

  // An arithmetic right shift keeps the upper bits, which floors.
  assign t_w     = pt_q[40:23];
  assign tp_w    = t_w + bptc_pkg::ColdShift;
  assign tt_full = t_w * t_w;
  assign u_full  = tp_w * tp_w;

  always_comb begin
    front_d.d1   = d1_s2_q;
    front_d.off  = $signed({3'b000, coeff_i.pressure_offset_coeff, 16'h0000})
                 + $signed(poff_q[40:7]);
    front_d.sens = $signed({3'b000, coeff_i.pressure_sensitivity_coeff, 15'h0000})
                 + $signed(psens_q[40:8]);
    front_d.t    = t_w;
    front_d.t2   = dd_q[47:31];
    front_d.tt   = tt_full[34:0];
    front_d.u    = u_full[33:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

// ----- rtl/bptc_corr.sv -----
// Stages 4 and 5: second-order correction of offset and sensitivity below
// 20 C, with the extra term below -15 C, and the temperature result.
module bptc_corr (
  input  logic               clk_i,
  input  logic [1:0]         en_i,
  input  bptc_pkg::front_t   front_i,
  output bptc_pkg::corr_t    corr_o
);

  typedef struct packed {
    logic [bptc_pkg::RawW-1:0]          d1;
    logic signed [34:0]                 off;
    logic signed [33:0]                 sens;
    logic [37:0]                        five_tt;
    logic [36:0]                        seven_u;
    logic [37:0]                        eleven_u;
    logic                               warm_n;
    logic                               cold;
    logic signed [bptc_pkg::TempW-1:0]  temp;
  } s4_t;

  s4_t               s4_q, s4_d;
  logic signed [18:0] temp_full;
  logic [16:0]        t2_sel;

  logic [36:0]        off2_base;
  logic [36:0]        off2_cold;
  logic [35:0]        sens2_base;
  logic [36:0]        sens2_cold;
  bptc_pkg::corr_t    corr_q, corr_d;

  assign t2_sel    = front_i.t[17] ? front_i.t2 : 17'd0;
  assign temp_full = front_i.t + bptc_pkg::TempBase - $signed({2'b00, t2_sel});

  always_comb begin
    s4_d.d1       = front_i.d1;
    s4_d.off      = front_i.off;
    s4_d.sens     = front_i.sens;
    s4_d.five_tt  = {3'b000, front_i.tt} + {1'b0, front_i.tt, 2'b00};
    s4_d.seven_u  = {front_i.u, 3'b000} - {3'b000, front_i.u};
    s4_d.eleven_u = {1'b0, front_i.u, 3'b000} + {3'b000, front_i.u, 1'b0}
                  + {4'h0, front_i.u};
    s4_d.warm_n   = front_i.t[17];
    s4_d.cold     = front_i.t < bptc_pkg::ColdLimit;
    s4_d.temp     = temp_full[bptc_pkg::TempW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s4_q <= s4_d;
    end
  end

  // All correction terms are non-negative, so the halvings are plain selects.
  assign off2_base  = s4_q.warm_n ? s4_q.five_tt[37:1] : 37'd0;
  assign sens2_base = s4_q.warm_n ? s4_q.five_tt[37:2] : 36'd0;
  assign off2_cold  = s4_q.cold ? s4_q.seven_u : 37'd0;
  assign sens2_cold = s4_q.cold ? s4_q.eleven_u[37:1] : 37'd0;

  always_comb begin
    corr_d.d1   = s4_q.d1;
    corr_d.off  = 40'(s4_q.off) - $signed({3'b000, off2_base})
                - $signed({3'b000, off2_cold});
    corr_d.sens = 38'(s4_q.sens) - $signed({2'b00, sens2_base})
                - $signed({1'b0, sens2_cold});
    corr_d.temp = s4_q.temp;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      corr_q <= corr_d;
    end
  end

  assign corr_o = corr_q;

endmodule

// ----- rtl/bptc_press.sv -----
// Stages 6 to 8: raw pressure times sensitivity as two partial products,
// their sum, then offset removal and the final scaling.
module bptc_press (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  bptc_pkg::corr_t    corr_i,
  output bptc_pkg::out_t     out_o
);

  // Stage 6.
  logic [42:0]                        plo_q, plo_d;
  logic signed [42:0]                 phi_q, phi_d;
  logic signed [39:0]                 off_s6_q, off_s7_q;
  logic signed [bptc_pkg::TempW-1:0]  temp_s6_q, temp_s7_q;

  // Stage 7.
  logic signed [61:0]                 prod_q, prod_d;

  // Stage 8.
  logic signed [41:0]                 diff_w;
  logic signed [26:0]                 press_w;
  bptc_pkg::out_t                     out_q, out_d;

  // Sensitivity split into an unsigned low half and a signed high half.
  assign plo_d = corr_i.d1 * corr_i.sens[18:0];
  assign phi_d = $signed({1'b0, corr_i.d1}) * $signed(corr_i.sens[37:19]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      plo_q     <= plo_d;
      phi_q     <= phi_d;
      off_s6_q  <= corr_i.off;
      temp_s6_q <= corr_i.temp;
    end
  end

  assign prod_d = $signed({phi_q, 19'h00000} + {19'h00000, plo_q});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q    <= prod_d;
      off_s7_q  <= off_s6_q;
      temp_s7_q <= temp_s6_q;
    end
  end

  // The product stays below 2^61 in magnitude, so the shifted difference
  // fits 42 bits and the pressure fits 27 bits: the 32-bit limits are never
  // reached and sign extension is the saturated value.
  assign diff_w  = $signed(prod_q[61:21]) - off_s7_q;
  assign press_w = diff_w[41:15];

  always_comb begin
    out_d.pressure_centi_mbar   = 32'(press_w);
    out_d.temperature_centi_deg = temp_s7_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

// ----- rtl/barometer_raw_to_pressure_temperature_core.sv -----
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+----------------------------------
// in        | input     | in_valid_i / in_stall_o  | in_data_i  (raw pressure, raw temp)
// out       | output    | out_valid_o / out_stall_i| out_data_o (pressure, temperature)
// cfg       | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One transfer is accepted every cycle unless an output stall has filled every stage;
// a result passes through the eight register stages of the arithmetic before it
// is offered at the output.
// Reset clears the calibration words and all stage valid bits.
// A stage takes new data whenever it is empty or the stage after it moves, so
// bubbles close up and an output stall only backs up into occupied stages.
module barometer_raw_to_pressure_temperature_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bptc_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bptc_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [bptc_pkg::CoeffW-1:0]       cfg_wdata_i
);

  bptc_pkg::coeff_t                   coeff_q, coeff_d;
  logic [bptc_pkg::NumStages-1:0]     valid_q, valid_d;
  logic [bptc_pkg::NumStages-1:0]     en;
  bptc_pkg::front_t                   front;
  bptc_pkg::corr_t                    corr;

  // Calibration words. Writes to an index beyond the list are dropped.
  always_comb begin
    coeff_d = coeff_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bptc_pkg::CfgPressSens:   coeff_d.pressure_sensitivity_coeff  = cfg_wdata_i;
        bptc_pkg::CfgPressOffset: coeff_d.pressure_offset_coeff       = cfg_wdata_i;
        bptc_pkg::CfgSensTemp:    coeff_d.sensitivity_temp_coeff      = cfg_wdata_i;
        bptc_pkg::CfgOffsetTemp:  coeff_d.offset_temp_coeff           = cfg_wdata_i;
        bptc_pkg::CfgRefTemp:     coeff_d.reference_temperature_coeff = cfg_wdata_i;
        bptc_pkg::CfgTempSlope:   coeff_d.temperature_slope_coeff     = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  // Stage enables: the last stage moves unless its result is held by a stall,
  // every earlier stage moves when it is empty or its successor moves.
  always_comb begin
    en[bptc_pkg::NumStages-1] = !valid_q[bptc_pkg::NumStages-1] || !out_stall_i;
    for (int k = bptc_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < bptc_pkg::NumStages; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[bptc_pkg::NumStages-1];

  // Stages 1 to 3: temperature difference, first-order offset, sensitivity
  // and temperature, and the squares for the cold-side correction.
  bptc_front u_front (
    .clk_i     (clk_i),
    .en_i      (en[2:0]),
    .in_data_i (in_data_i),
    .coeff_i   (coeff_q),
    .front_o   (front)
  );

  // Stages 4 and 5: second-order correction and the temperature result.
  bptc_corr u_corr (
    .clk_i   (clk_i),
    .en_i    (en[4:3]),
    .front_i (front),
    .corr_o  (corr)
  );

  // Stages 6 to 8: pressure product, offset removal and output register.
  bptc_press u_press (
    .clk_i  (clk_i),
    .en_i   (en[7:5]),
    .corr_i (corr),
    .out_o  (out_data_o)
  );

endmodule

// ----- rtl/bptc_chk.sv -----
module bptc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input bptc_pkg::in_t                 in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input bptc_pkg::out_t                out_data_o,
  input logic                          cfg_we_i,
  input logic [bptc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [bptc_pkg::CoeffW-1:0]   cfg_wdata_i
);

  // A held result keeps its valid until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A held result keeps its value until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // With the output register empty the pipeline can always take an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

  // Back-pressure on the input only ever comes from a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without an output stall");

endmodule

bind barometer_raw_to_pressure_temperature_core bptc_chk u_bptc_chk (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import bptc_pkg::*;

  // Number of real calibration registers; any higher index is a stray write
  // that the block must ignore.
  localparam int unsigned NumCoeffs = 6;
  localparam longint PressMax = 64'sd2147483647;
  localparam longint PressMin = -64'sd2147483648;

  // The calibration words, the expected results still to come and the
  // arithmetic that turns one raw pair into compensated values.
  class reading_ledger;
    coeff_t coeffs = '0;
    out_t   awaited[$];
    int     failures;
    int     compared;
    int     cold_readings;
    int     very_cold_readings;

    function void store_coeff(logic [CfgIdxW-1:0] idx, logic [CoeffW-1:0] val);
      case (idx)
        CfgPressSens:   coeffs.pressure_sensitivity_coeff = val;
        CfgPressOffset: coeffs.pressure_offset_coeff = val;
        CfgSensTemp:    coeffs.sensitivity_temp_coeff = val;
        CfgOffsetTemp:  coeffs.offset_temp_coeff = val;
        CfgRefTemp:     coeffs.reference_temperature_coeff = val;
        CfgTempSlope:   coeffs.temperature_slope_coeff = val;
        default: ;
      endcase
    endfunction

    // All arithmetic is in 64-bit signed integers; >>> on a signed value
    // rounds towards minus infinity, as the sensor's formulae expect.
    function out_t compensate(in_t r);
      longint d1, d2, dt, off, sens, t, t2, off2, sens2, u, p, temp;
      out_t   res;
      d1 = longint'(r.raw_pressure);
      d2 = longint'(r.raw_temperature);
      dt = d2 - longint'(coeffs.reference_temperature_coeff) * 256;
      off = longint'(coeffs.pressure_offset_coeff) * 65536
          + ((longint'(coeffs.offset_temp_coeff) * dt) >>> 7);
      sens = longint'(coeffs.pressure_sensitivity_coeff) * 32768
           + ((longint'(coeffs.sensitivity_temp_coeff) * dt) >>> 8);
      t = (dt * longint'(coeffs.temperature_slope_coeff)) >>> 23;
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      // Below 20 C the second-order terms apply, below -15 C an extra one.
      if (t < 0) begin
        cold_readings++;
        t2 = (dt * dt) >>> 31;
        off2 = (5 * (t * t)) >>> 1;
        sens2 = off2 >>> 1;
        if (t < ColdLimit) begin
          very_cold_readings++;
          u = (t + ColdShift) * (t + ColdShift);
          off2 += 7 * u;
          sens2 += (11 * u) >>> 1;
        end
      end
      temp = t + TempBase - t2;
      off -= off2;
      sens -= sens2;
      p = (((d1 * sens) >>> 21) - off) >>> 15;
      if (p > PressMax) p = PressMax;
      if (p < PressMin) p = PressMin;
      res.pressure_centi_mbar = p[PressW-1:0];
      res.temperature_centi_deg = temp[TempW-1:0];
      return res;
    endfunction

    function void note_reading(in_t r);
      awaited.push_back(compensate(r));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: pressure %0d temperature %0d",
               got.pressure_centi_mbar, got.temperature_centi_deg);
        failures++;
        return;
      end
      want = awaited.pop_front();
      compared++;
      if (got.pressure_centi_mbar !== want.pressure_centi_mbar) begin
        $error("pressure_centi_mbar: expected %0d, got %0d",
               want.pressure_centi_mbar, got.pressure_centi_mbar);
        failures++;
      end
      if (got.temperature_centi_deg !== want.temperature_centi_deg) begin
        $error("temperature_centi_deg: expected %0d, got %0d",
               want.temperature_centi_deg, got.temperature_centi_deg);
        failures++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // Every input of the block starts from a known value.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CoeffW-1:0]   cfg_wdata = '0;

  reading_ledger book = new();
  int            idle_pct = 22;
  int            stall_pct = 22;
  int            calib_sets = 0;

  barometer_raw_to_pressure_temperature_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The output side: a result transfer happens at an edge where valid is high
  // and our stall is low. Both are read just after the edge, so they still
  // hold the values that the edge saw. The stall for the next cycle is then
  // drawn at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_result(out_data);
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Safety net in case the block stops moving altogether.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [CoeffW-1:0] coeff_for(coeff_t c, logic [CfgIdxW-1:0] idx);
    case (idx)
      CfgPressSens:   return c.pressure_sensitivity_coeff;
      CfgPressOffset: return c.pressure_offset_coeff;
      CfgSensTemp:    return c.sensitivity_temp_coeff;
      CfgOffsetTemp:  return c.offset_temp_coeff;
      CfgRefTemp:     return c.reference_temperature_coeff;
      CfgTempSlope:   return c.temperature_slope_coeff;
      default:        return '0;
    endcase
  endfunction

  // Finds a raw temperature whose first-order temperature offset is exactly
  // the target, so that the cold thresholds can be hit on either side.
  // Returns 0 when the slope is zero or the raw value would not fit.
  function automatic bit raw_temp_for(input longint target, input coeff_t c,
                                      output logic [RawW-1:0] raw);
    longint scaled, slope, dt, d2;
    slope = longint'(c.temperature_slope_coeff);
    raw = '0;
    if (slope == 0) return 1'b0;
    scaled = target * (longint'(1) <<< 23);
    // Integer division truncates towards zero, which is the ceiling for a
    // negative quotient; the positive case needs rounding up by hand.
    dt = (scaled >= 0) ? (scaled + slope - 1) / slope : scaled / slope;
    d2 = dt + longint'(c.reference_temperature_coeff) * 256;
    raw = d2[RawW-1:0];
    return (d2 >= 0) && (d2 < (longint'(1) <<< RawW));
  endfunction

  // Writes all six calibration words, then the stray indices above them with
  // random data, which the block must drop. The enable only falls after the
  // last write, so it is never lowered and raised in one time step.
  task automatic write_calibration(input coeff_t c);
    logic [CoeffW-1:0] val;
    for (int i = 0; i < 2 ** CfgIdxW; i++) begin
      if (i < NumCoeffs) val = coeff_for(c, CfgIdxW'(i));
      else val = CoeffW'($urandom_range(0, 65535));
      cfg_we    <= 1'b1;
      cfg_idx   <= CfgIdxW'(i);
      cfg_wdata <= val;
      @(posedge clk);
      book.store_coeff(CfgIdxW'(i), val);
    end
    cfg_we <= 1'b0;
    calib_sets++;
  endtask

  // Offers one raw pair and holds it steady until the input transfer takes
  // place. Valid is only dropped when a random idle cycle is inserted, so a
  // back-to-back stream keeps it high without a glitch.
  task automatic send_reading(input logic [RawW-1:0] press, input logic [RawW-1:0] temp);
    in_t item;
    item.raw_pressure = press;
    item.raw_temperature = temp;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_reading(item);
  endtask

  // Most raw temperatures are drawn over the whole range; a quarter are aimed
  // at temperatures around the two cold thresholds.
  task automatic send_random_reading();
    logic [RawW-1:0] temp;
    if ($urandom_range(0, 3) != 0 ||
        !raw_temp_for(longint'($urandom_range(0, 9000)) - 6000, book.coeffs, temp)) begin
      temp = RawW'($urandom_range(0, 2 ** RawW - 1));
    end
    send_reading(RawW'($urandom_range(0, 2 ** RawW - 1)), temp);
  endtask

  // Drops valid, waits until every result is back and then lets the pipeline run
  // empty, so that calibration words only change while the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (NumStages + 2) @(posedge clk);
  endtask

  initial begin
    coeff_t          c;
    logic [RawW-1:0] temp;
    logic [RawW-1:0] ref_raw;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset every calibration word is zero.
    send_reading('0, '0);
    send_reading('1, '1);
    settle();

    // A typical factory calibration, with the temperature thresholds hit
    // exactly: no correction at zero offset, then just below 20 C, exactly
    // -15 C and just below it.
    c = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
    write_calibration(c);
    ref_raw = {c.reference_temperature_coeff, 8'h00};
    send_reading('0, ref_raw);
    send_reading('1, ref_raw);
    for (int k = 0; k < 5; k++) begin
      longint target;
      case (k)
        0: target = 1;
        1: target = 0;
        2: target = -1;
        3: target = -3500;
        default: target = -3501;
      endcase
      if (raw_temp_for(target, c, temp)) send_reading(24'h800000, temp);
    end
    send_reading('1, '0);
    send_reading('0, '0);
    send_reading('1, '1);
    settle();

    // Every word at its maximum: the coldest possible readings.
    c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    write_calibration(c);
    send_reading('1, '0);
    send_reading('0, '0);
    send_reading('1, '1);
    settle();

    // Reference temperature zero with a steep slope: the temperature runs far
    // past 16 bits and wraps.
    c.reference_temperature_coeff = '0;
    write_calibration(c);
    send_reading('1, '1);
    send_reading('0, '1);
    send_reading(24'h800000, 24'h400000);

    // Random calibrations; the fourth set runs with no idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      idle_pct  = (ph == 3) ? 0 : 22;
      stall_pct = (ph == 3) ? 0 : 22;
      c.pressure_sensitivity_coeff  = CoeffW'($urandom_range(0, 65535));
      c.pressure_offset_coeff       = CoeffW'($urandom_range(0, 65535));
      c.sensitivity_temp_coeff      = CoeffW'($urandom_range(0, 65535));
      c.offset_temp_coeff           = CoeffW'($urandom_range(0, 65535));
      c.reference_temperature_coeff = CoeffW'($urandom_range(0, 65535));
      c.temperature_slope_coeff     = CoeffW'($urandom_range(0, 65535));
      write_calibration(c);
      repeat (92) send_random_reading();
    end
    idle_pct = 22;
    stall_pct = 22;

    settle();
    $display("testbench: %0d results compared over %0d calibration sets",
             book.compared, calib_sets);
    $display("testbench: %0d readings below 20 C, %0d of them below -15 C",
             book.cold_readings, book.very_cold_readings);
    if (book.failures == 0 && book.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- barometer_raw_to_pressure_temperature_core.f -----
rtl/bptc_pkg.sv
rtl/bptc_front.sv
rtl/bptc_corr.sv
rtl/bptc_press.sv
rtl/barometer_raw_to_pressure_temperature_core.sv
rtl/bptc_chk.sv
test/testbench.sv
